// ===== hdl/qdp_pkg.sv =====
// ----------------------------------------------------------------------------
// qdp_pkg
// Shared widths, codes, configuration record and helper functions for the
// quadrature detent and press decoder.
// ----------------------------------------------------------------------------
package qdp_pkg;

  // tick counters and step accumulator
  localparam int TIME_W  = 20;
  localparam int ACCUM_W = 8;

  // configuration field widths
  localparam int THR_W      = 4;
  localparam int CFG_TIME_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // width that holds both a counter and a configured tick count
  localparam int CMP_W = 33;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETENT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DETENT_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOCKOUT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME  = 3'd4;

  // configuration reset values
  localparam logic [THR_W-1:0]      RST_DETENT_THRESHOLD = 4'd4;
  localparam logic [CFG_TIME_W-1:0] RST_MIN_DETENT_GAP   = 20'd45000;
  localparam logic [CFG_TIME_W-1:0] RST_DEBOUNCE_DELAY   = 20'd5000;
  localparam logic [CFG_TIME_W-1:0] RST_PRESS_LOCKOUT    = 20'd80000;
  localparam logic [CFG_TIME_W-1:0] RST_LONG_PRESS_TIME  = 20'd800000;

  // rotation event codes
  localparam logic [1:0] DET_NONE = 2'd0;
  localparam logic [1:0] DET_CW   = 2'd1;
  localparam logic [1:0] DET_CCW  = 2'd2;

  // press event codes
  localparam logic [1:0] PRS_NONE  = 2'd0;
  localparam logic [1:0] PRS_SHORT = 2'd1;
  localparam logic [1:0] PRS_LONG  = 2'd2;

  // quadrature step codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DN   = 2'd2;

  // accumulator limits
  localparam logic signed [ACCUM_W-1:0] ACC_MAX = {1'b0, {(ACCUM_W-1){1'b1}}};
  localparam logic signed [ACCUM_W-1:0] ACC_MIN = {1'b1, {(ACCUM_W-1){1'b0}}};

  typedef struct packed {
    logic [THR_W-1:0]      detent_threshold;
    logic [CFG_TIME_W-1:0] min_detent_gap;
    logic [CFG_TIME_W-1:0] debounce_delay;
    logic [CFG_TIME_W-1:0] press_lockout;
    logic [CFG_TIME_W-1:0] long_press_time;
  } qdp_cfg_t;

  // previous and current A/B pair to a step
  function automatic logic [1:0] step_of(input logic [3:0] idx);
    logic [1:0] code;
    unique case (idx) inside
      4'd2, 4'd4, 4'd11, 4'd13: code = STEP_UP;
      4'd1, 4'd7, 4'd8, 4'd14:  code = STEP_DN;
      default:                  code = STEP_NONE;
    endcase
    return code;
  endfunction

  // counter increment that sticks at all ones
  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    return (v == {TIME_W{1'b1}}) ? v : TIME_W'(v + 1'b1);
  endfunction

  // counter compared with a configured tick count
  function automatic logic time_ge(input logic [TIME_W-1:0] t,
                                   input logic [CFG_TIME_W-1:0] c);
    return CMP_W'(t) >= CMP_W'(c);
  endfunction

  function automatic logic time_gt(input logic [TIME_W-1:0] t,
                                   input logic [CFG_TIME_W-1:0] c);
    return CMP_W'(t) > CMP_W'(c);
  endfunction

endpackage

// ===== hdl/qdp_if.sv =====
// ----------------------------------------------------------------------------
// qdp_if
// Valid/ready channels of the decoder: sample input, event output and
// configuration write.
// ----------------------------------------------------------------------------
interface qdp_in_if;
  logic valid;
  logic ready;
  logic enc_a;
  logic enc_b;
  logic button_level;

  modport source (output valid, output enc_a, output enc_b, output button_level,
                  input ready);
  modport sink (input valid, input enc_a, input enc_b, input button_level,
                output ready);
endinterface

interface qdp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] detent_event;
  logic [1:0] press_event;

  modport source (output valid, output detent_event, output press_event,
                  input ready);
  modport sink (input valid, input detent_event, input press_event,
                output ready);
endinterface

interface qdp_cfg_if import qdp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/qdp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qdp_cfg_regs
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module qdp_cfg_regs import qdp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  qdp_cfg_if.sink  cfg,
  output qdp_cfg_t regs
);

  // always able to take a write request
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.detent_threshold <= RST_DETENT_THRESHOLD;
      regs.min_detent_gap   <= RST_MIN_DETENT_GAP;
      regs.debounce_delay   <= RST_DEBOUNCE_DELAY;
      regs.press_lockout    <= RST_PRESS_LOCKOUT;
      regs.long_press_time  <= RST_LONG_PRESS_TIME;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DETENT_THRESHOLD: regs.detent_threshold <= cfg.data[THR_W-1:0];
        REG_MIN_DETENT_GAP:   regs.min_detent_gap   <= cfg.data[CFG_TIME_W-1:0];
        REG_DEBOUNCE_DELAY:   regs.debounce_delay   <= cfg.data[CFG_TIME_W-1:0];
        REG_PRESS_LOCKOUT:    regs.press_lockout    <= cfg.data[CFG_TIME_W-1:0];
        REG_LONG_PRESS_TIME:  regs.long_press_time  <= cfg.data[CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/qdp_rotation.sv =====
// ----------------------------------------------------------------------------
// qdp_rotation
// Quadrature step decode, direction-clearing saturating accumulator and
// gap-limited detent events.
// ----------------------------------------------------------------------------
module qdp_rotation import qdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       enc_a,
  input  logic       enc_b,
  input  qdp_cfg_t   regs,
  output logic [1:0] detent_event
);

  logic [1:0]                last_ab;
  logic signed [ACCUM_W-1:0] step_accum;
  logic [TIME_W-1:0]         since_detent;

  logic [1:0]                last_ab_next;
  logic signed [ACCUM_W-1:0] step_accum_next;
  logic [TIME_W-1:0]         since_detent_next;

  logic [1:0]                step;
  logic signed [ACCUM_W-1:0] acc_clr;
  logic signed [ACCUM_W-1:0] acc_add;
  logic signed [ACCUM_W-1:0] thr_s;
  logic [THR_W-1:0]          thr_eff;
  logic [TIME_W-1:0]         sd_inc;

  // step decode and accumulator update
  always_comb begin
    last_ab_next      = {enc_a, enc_b};
    step              = step_of({last_ab, enc_a, enc_b});
    sd_inc            = sat_inc(since_detent);
    thr_eff           = (regs.detent_threshold == '0) ? THR_W'(1)
                                                      : regs.detent_threshold;
    thr_s             = $signed(ACCUM_W'(thr_eff));
    acc_clr           = step_accum;
    acc_add           = step_accum;
    step_accum_next   = step_accum;
    since_detent_next = sd_inc;
    detent_event      = DET_NONE;

    if (step != STEP_NONE) begin
      // reversal clears the accumulator
      if ((step == STEP_UP && step_accum < 0) || (step == STEP_DN && step_accum > 0)) begin
        acc_clr = '0;
      end
      // saturating add
      acc_add = acc_clr;
      if (step == STEP_UP && acc_clr != ACC_MAX) begin
        acc_add = acc_clr + ACCUM_W'(1);
      end else if (step == STEP_DN && acc_clr != ACC_MIN) begin
        acc_add = acc_clr - ACCUM_W'(1);
      end
      step_accum_next = acc_add;
      // detent once the gap has passed
      if (time_ge(sd_inc, regs.min_detent_gap)) begin
        if (acc_add >= thr_s) begin
          step_accum_next   = acc_add - thr_s;
          detent_event      = DET_CW;
          since_detent_next = '0;
        end else if (acc_add <= -thr_s) begin
          step_accum_next   = acc_add + thr_s;
          detent_event      = DET_CCW;
          since_detent_next = '0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_ab      <= 2'b11;
      step_accum   <= '0;
      since_detent <= '1;
    end else if (advance) begin
      last_ab      <= last_ab_next;
      step_accum   <= step_accum_next;
      since_detent <= since_detent_next;
    end
  end

endmodule

// ===== hdl/qdp_button.sv =====
// ----------------------------------------------------------------------------
// qdp_button
// Button debounce, press lockout and short/long classification at release.
// ----------------------------------------------------------------------------
module qdp_button import qdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       button_level,
  input  qdp_cfg_t   regs,
  output logic [1:0] press_event
);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HOLD     = 2'd2;

  logic [1:0]        button_phase;
  logic [TIME_W-1:0] phase_timer;
  logic [TIME_W-1:0] since_press;
  logic              prev_button;

  logic [1:0]        button_phase_next;
  logic [TIME_W-1:0] phase_timer_next;
  logic [TIME_W-1:0] since_press_next;
  logic [TIME_W-1:0] pt_inc;

  // press sequencer
  always_comb begin
    pt_inc            = sat_inc(phase_timer);
    since_press_next  = sat_inc(since_press);
    button_phase_next = button_phase;
    phase_timer_next  = phase_timer;
    press_event       = PRS_NONE;

    unique case (button_phase)
      PH_DEBOUNCE: begin
        phase_timer_next = pt_inc;
        if (time_ge(pt_inc, regs.debounce_delay)) begin
          if (!button_level && time_gt(since_press_next, regs.press_lockout)) begin
            button_phase_next = PH_HOLD;
            phase_timer_next  = '0;
            since_press_next  = '0;
          end else begin
            button_phase_next = PH_IDLE;
          end
        end
      end
      PH_HOLD: begin
        phase_timer_next = pt_inc;
        if (button_level) begin
          press_event       = time_ge(pt_inc, regs.long_press_time) ? PRS_LONG : PRS_SHORT;
          button_phase_next = PH_IDLE;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        button_phase_next = PH_IDLE;
        if (prev_button && !button_level) begin
          button_phase_next = PH_DEBOUNCE;
          phase_timer_next  = '0;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      button_phase <= PH_IDLE;
      phase_timer  <= '0;
      since_press  <= '0;
      prev_button  <= 1'b1;
    end else if (advance) begin
      button_phase <= button_phase_next;
      phase_timer  <= phase_timer_next;
      since_press  <= since_press_next;
      prev_button  <= button_level;
    end
  end

endmodule

// ===== hdl/quadrature_detent_and_press_decoder.sv =====
// One sample request per time-base tick goes in, and exactly one event request
// comes out for it, in order. The block takes a new sample every clock cycle
// while the event side is ready: the sample is captured in an input register,
// decoded by combinational logic (step table, accumulator, tick counters and
// press sequencer) and written to a result register, so the sustained rate
// is one sample per cycle, limited by the combinational decode between those
// two registers and by backpressure. Backpressure on the event side stalls the
// decode and, once both registers are full, the sample side.
// Configuration writes are always taken and should be made while idle.
// ----------------------------------------------------------------------------
// quadrature_detent_and_press_decoder
// Top level: input and result registers around the rotation and button
// decoders, plus the configuration registers.
// ----------------------------------------------------------------------------
module quadrature_detent_and_press_decoder import qdp_pkg::*; (
  input logic      clk,
  input logic      rst,
  qdp_in_if.sink   samples,
  qdp_out_if.source events,
  qdp_cfg_if.sink  cfg
);

  qdp_cfg_t   regs;

  logic       in_valid_q;
  logic       in_enc_a;
  logic       in_enc_b;
  logic       in_button;
  logic       out_valid_q;
  logic [1:0] out_detent;
  logic [1:0] out_press;
  logic       advance;
  logic [1:0] det_evt;
  logic [1:0] prs_evt;

  // handshake control
  assign advance       = in_valid_q && (!out_valid_q || events.ready);
  assign samples.ready = !in_valid_q || advance;

  assign events.valid        = out_valid_q;
  assign events.detent_event = out_detent;
  assign events.press_event  = out_press;

  // configuration registers
  qdp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // rotation decode
  qdp_rotation u_rot (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .enc_a        (in_enc_a),
    .enc_b        (in_enc_b),
    .regs         (regs),
    .detent_event (det_evt)
  );

  // button decode
  qdp_button u_btn (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .button_level (in_button),
    .regs         (regs),
    .press_event  (prs_evt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_enc_a  <= samples.enc_a;
      in_enc_b  <= samples.enc_b;
      in_button <= samples.button_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (events.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_detent <= det_evt;
      out_press  <= prs_evt;
    end
  end

`ifndef SYNTHESIS
  // a decoded sample always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid_q)
    else $error("decoded sample did not reach the result register");

  // an accepted sample is held in the input register
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> in_valid_q)
    else $error("accepted sample lost from the input register");

  // no decode without a held sample
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !in_valid_q |-> !advance)
    else $error("decode ran without a sample");

  // event codes stay within their defined values
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid_q |-> ((out_detent == DET_NONE || out_detent == DET_CW ||
                      out_detent == DET_CCW) &&
                     (out_press == PRS_NONE || out_press == PRS_SHORT ||
                      out_press == PRS_LONG)))
    else $error("undefined event code in result register");
`endif

endmodule
